FILE: hdl/tpsk_pkg.sv
// Shared widths, constants and the log2 table generator for the thin-plate spline kernel.
`default_nettype none
package tpsk_pkg;
  localparam int COORD_W  = 32;
  localparam int DIFF_W   = 32;
  localparam int SQ_W     = 64;
  localparam int SUM_W    = 66;
  localparam int ROOT_W   = 33;
  localparam int EXP_W    = 6;
  localparam int MIN_W    = 31;
  localparam int Q30_W    = 30;
  localparam int LOG_W    = 31;
  localparam int LN_W     = 37;
  localparam int LNMAG_W  = 36;
  localparam int HALF_W   = 33;
  localparam int PART_W   = HALF_W + LNMAG_W;
  localparam int PROD_W   = SUM_W + LNMAG_W;
  localparam int OUT_W    = 64;
  localparam logic [Q30_W-1:0] LN2_Q30 = 30'd744261118;

  // log2(1 + k/2^l) in Q.30, truncated, bit by bit
  function automatic logic [LOG_W-1:0] rom_log2(input int k, input int l);
    logic [63:0]       x;
    logic [LOG_W-1:0]  y;
    y = '0;
    if (k >= (1 << l)) begin
      y = LOG_W'(64'd1 << 30);
    end else begin
      x = (64'd1 << 30) + (64'(k) << (30 - l));
      for (int i = 1; i <= 30; i++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          y[30-i] = 1'b1;
        end
      end
    end
    return y;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/tpsk_isqrt.sv
// Pipelined digit-by-digit integer square root, three digits per stage, with side data.
`default_nettype none
module tpsk_isqrt #(
  parameter int RAD_W  = 66,
  parameter int SIDE_W = 66
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire logic [RAD_W-1:0]      in_rad,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic [RAD_W/2-1:0]         out_root,
  output logic [SIDE_W-1:0]          out_side
);
  localparam int STEPS = RAD_W / 2;
  localparam int PER   = 3;
  localparam int NST   = (STEPS + PER - 1) / PER;
  localparam int RT_W  = STEPS;
  localparam int REM_W = STEPS + 4;

  logic              v_r    [NST];
  logic [RAD_W-1:0]  rad_r  [NST];
  logic [RT_W-1:0]   root_r [NST];
  logic [REM_W-1:0]  rem_r  [NST];
  logic [SIDE_W-1:0] side_r [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic              src_v;
    logic [RAD_W-1:0]  src_rad;
    logic [RT_W-1:0]   src_root;
    logic [REM_W-1:0]  src_rem;
    logic [SIDE_W-1:0] src_side;
    logic [RAD_W-1:0]  rad_nxt;
    logic [RT_W-1:0]   root_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [REM_W-1:0]  trial;

    if (s == 0) begin : g_head
      assign src_v    = in_valid;
      assign src_rad  = in_rad;
      assign src_root = '0;
      assign src_rem  = '0;
      assign src_side = in_side;
    end else begin : g_body
      assign src_v    = v_r[s-1];
      assign src_rad  = rad_r[s-1];
      assign src_root = root_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_side = side_r[s-1];
    end

    always_comb begin
      rad_nxt  = src_rad;
      root_nxt = src_root;
      rem_nxt  = src_rem;
      trial    = '0;
      for (int j = 0; j < PER; j++) begin
        if (s * PER + j < STEPS) begin
          rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[RAD_W-1 -: 2]};
          rad_nxt = rad_nxt << 2;
          trial   = REM_W'({root_nxt, 2'b01});
          if (rem_nxt >= trial) begin
            rem_nxt  = rem_nxt - trial;
            root_nxt = {root_nxt[RT_W-2:0], 1'b1};
          end else begin
            root_nxt = {root_nxt[RT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[s]  <= rad_nxt;
        root_r[s] <= root_nxt;
        rem_r[s]  <= rem_nxt;
        side_r[s] <= src_side;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_root  = root_r[NST-1];
  assign out_side  = side_r[NST-1];
endmodule
`default_nettype wire

FILE: hdl/thin_plate_spline_kernel.sv
// Top level: thin-plate spline kernel r^2 ln r, fully pipelined.
//
// channel | dir | signals                               | content
// in      | in  | in_tvalid/in_tready/in_tdata[191:0]    | point x,y,z, centre x,y,z
// out     | out | out_tvalid/out_tready/out_tdata/tuser  | kernel_value, saturated
// cfg     | in  | cfg_valid/cfg_ready/cfg_data[30:0]     | min_distance
//
// One request per cycle while the pipe advances; 11 root stages plus 14 arithmetic stages.
// Root stages each resolve three result bits; the wide final product is split in two halves.
// The whole pipe advances while the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears all valid bits and sets min_distance to 1.
`default_nettype none
module thin_plate_spline_kernel #(
  parameter int FRACTION_BITS  = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // point_x, point_y, point_z, center_x, center_y, center_z (32 bits each)
  input  wire logic [191:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // kernel_value
  output logic [63:0]        out_tdata,
  // saturated
  output logic               out_tuser,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [30:0]   cfg_data
);
  localparam int L     = LOG_TABLE_BITS;
  localparam int T_W   = 30 - L;
  localparam int ROM_N = (1 << L) + 1;
  localparam int SH    = FRACTION_BITS + 30;
  localparam int DP_W  = tpsk_pkg::LOG_W + T_W;
  localparam int LP_W  = tpsk_pkg::LOG_W + tpsk_pkg::Q30_W;
  localparam int RND_W = tpsk_pkg::PROD_W + 1;
  localparam int Q_W   = RND_W - SH;
  localparam int CMP_W = (Q_W > tpsk_pkg::OUT_W) ? Q_W : tpsk_pkg::OUT_W;

  logic adv;
  logic [tpsk_pkg::MIN_W-1:0] min_dist_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= tpsk_pkg::MIN_W'(1);
    end else if (cfg_valid) begin
      min_dist_r <= cfg_data;
    end
  end

  logic [tpsk_pkg::LOG_W-1:0] rom [ROM_N];
  for (genvar k = 0; k < ROM_N; k++) begin : g_rom
    localparam logic [tpsk_pkg::LOG_W-1:0] ENTRY = tpsk_pkg::rom_log2(k, L);
    assign rom[k] = ENTRY;
  end

  // differences
  logic                        d_v_r;
  logic [tpsk_pkg::DIFF_W-1:0] d_abs_r [3];
  logic [tpsk_pkg::DIFF_W-1:0] d_abs_nxt [3];

  always_comb begin
    logic signed [tpsk_pkg::COORD_W:0] df;
    df = '0;
    for (int i = 0; i < 3; i++) begin
      df = $signed({in_tdata[32*i+31], in_tdata[32*i +: 32]})
         - $signed({in_tdata[32*(i+3)+31], in_tdata[32*(i+3) +: 32]});
      d_abs_nxt[i] = df[tpsk_pkg::COORD_W] ? tpsk_pkg::DIFF_W'(-df)
                                           : tpsk_pkg::DIFF_W'(df);
    end
  end

  // squares
  logic                      q_v_r;
  logic [tpsk_pkg::SQ_W-1:0] q_sq_r [3];
  // sum
  logic                       s_v_r;
  logic [tpsk_pkg::SUM_W-1:0] s_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      q_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= in_tvalid;
      q_v_r <= d_v_r;
      s_v_r <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_abs_r[i] <= d_abs_nxt[i];
        q_sq_r[i]  <= tpsk_pkg::SQ_W'(d_abs_r[i]) * tpsk_pkg::SQ_W'(d_abs_r[i]);
      end
      s_sum_r <= tpsk_pkg::SUM_W'(q_sq_r[0]) + tpsk_pkg::SUM_W'(q_sq_r[1])
               + tpsk_pkg::SUM_W'(q_sq_r[2]);
    end
  end

  logic                        rt_v;
  logic [tpsk_pkg::ROOT_W-1:0] rt_root;
  logic [tpsk_pkg::SUM_W-1:0]  rt_sum;

  tpsk_isqrt #(
    .RAD_W  (tpsk_pkg::SUM_W),
    .SIDE_W (tpsk_pkg::SUM_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s_v_r),
    .in_rad    (s_sum_r),
    .in_side   (s_sum_r),
    .out_valid (rt_v),
    .out_root  (rt_root),
    .out_side  (rt_sum)
  );

  // stage a: exponent and short-distance test
  logic [tpsk_pkg::EXP_W-1:0] a_e_nxt;
  always_comb begin
    a_e_nxt = '0;
    for (int i = 0; i < tpsk_pkg::ROOT_W; i++) begin
      if (rt_root[i]) a_e_nxt = tpsk_pkg::EXP_W'(i);
    end
  end

  logic                        a_v_r, a_short_r;
  logic [tpsk_pkg::EXP_W-1:0]  a_e_r;
  logic [tpsk_pkg::ROOT_W-1:0] a_r_r;
  logic [tpsk_pkg::SUM_W-1:0]  a_s_r;

  // stage b: normalise, integer part of ln
  logic [62:0]                     b_nrm;
  logic signed [7:0]               b_ed;
  logic signed [tpsk_pkg::LN_W-1:0] b_whole_nxt;
  assign b_nrm       = {a_r_r, 30'b0} >> a_e_r;
  assign b_ed        = $signed(8'(a_e_r)) - $signed(8'(FRACTION_BITS));
  assign b_whole_nxt = tpsk_pkg::LN_W'(b_ed)
                     * $signed(tpsk_pkg::LN_W'(tpsk_pkg::LN2_Q30));

  logic                              b_v_r, b_short_r;
  logic [L-1:0]                      b_k_r;
  logic [T_W-1:0]                    b_t_r;
  logic signed [tpsk_pkg::LN_W-1:0]  b_whole_r;
  logic [tpsk_pkg::SUM_W-1:0]        b_s_r;

  // stage c: table lookup
  logic [L:0] c_i0, c_i1;
  assign c_i0 = {1'b0, b_k_r};
  assign c_i1 = c_i0 + (L+1)'(1);

  logic                              c_v_r, c_short_r;
  logic [tpsk_pkg::LOG_W-1:0]        c_t0_r, c_diff_r;
  logic [T_W-1:0]                    c_t_r;
  logic signed [tpsk_pkg::LN_W-1:0]  c_whole_r;
  logic [tpsk_pkg::SUM_W-1:0]        c_s_r;

  // stage d: interpolation product
  logic                              dd_v_r, dd_short_r;
  logic [tpsk_pkg::LOG_W-1:0]        dd_t0_r;
  logic [DP_W-1:0]                   dd_prod_r;
  logic signed [tpsk_pkg::LN_W-1:0]  dd_whole_r;
  logic [tpsk_pkg::SUM_W-1:0]        dd_s_r;

  // stage e: log2 of mantissa
  logic                              e_v_r, e_short_r;
  logic [tpsk_pkg::LOG_W-1:0]        e_l2m_r;
  logic signed [tpsk_pkg::LN_W-1:0]  e_whole_r;
  logic [tpsk_pkg::SUM_W-1:0]        e_s_r;

  // stage f: times ln 2
  logic                              f_v_r, f_short_r;
  logic [LP_W-1:0]                   f_lp_r;
  logic signed [tpsk_pkg::LN_W-1:0]  f_whole_r;
  logic [tpsk_pkg::SUM_W-1:0]        f_s_r;

  // stage g: ln magnitude and sign
  logic signed [tpsk_pkg::LN_W-1:0] g_ln;
  assign g_ln = f_whole_r + $signed(tpsk_pkg::LN_W'(f_lp_r >> 30));

  logic                          g_v_r, g_short_r, g_neg_r;
  logic [tpsk_pkg::LNMAG_W-1:0]  g_mag_r;
  logic [tpsk_pkg::SUM_W-1:0]    g_s_r;

  // stage h: partial products
  logic                          h_v_r, h_short_r, h_neg_r;
  logic [tpsk_pkg::PART_W-1:0]   h_lo_r, h_hi_r;

  // stage i: full product
  logic                          i_v_r, i_short_r, i_neg_r;
  logic [tpsk_pkg::PROD_W-1:0]   i_full_r;

  // stage j: round and saturate
  logic [RND_W-1:0]             j_rnd;
  logic [Q_W-1:0]               j_q;
  logic [CMP_W-1:0]             j_qw;
  logic [CMP_W-1:0]             j_lim;
  logic                         j_sat_nxt;
  logic [tpsk_pkg::OUT_W-1:0]   j_mag_nxt;
  assign j_rnd     = RND_W'(i_full_r) + (RND_W'(1) << (SH - 1));
  assign j_q       = Q_W'(j_rnd >> SH);
  assign j_qw      = CMP_W'(j_q);
  assign j_lim     = i_neg_r ? (CMP_W'(1) << 63) : ((CMP_W'(1) << 63) - CMP_W'(1));
  assign j_sat_nxt = j_qw > j_lim;
  assign j_mag_nxt = j_sat_nxt ? tpsk_pkg::OUT_W'(j_lim) : tpsk_pkg::OUT_W'(j_qw);

  logic                         j_v_r, j_short_r, j_neg_r, j_sat_r;
  logic [tpsk_pkg::OUT_W-1:0]   j_mag_r;

  // output
  logic                         o_v_r, o_sat_r;
  logic [tpsk_pkg::OUT_W-1:0]   o_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      dd_v_r <= 1'b0;
      e_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
      g_v_r  <= 1'b0;
      h_v_r  <= 1'b0;
      i_v_r  <= 1'b0;
      j_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      a_v_r  <= rt_v;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      dd_v_r <= c_v_r;
      e_v_r  <= dd_v_r;
      f_v_r  <= e_v_r;
      g_v_r  <= f_v_r;
      h_v_r  <= g_v_r;
      i_v_r  <= h_v_r;
      j_v_r  <= i_v_r;
      o_v_r  <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_short_r  <= rt_root <= tpsk_pkg::ROOT_W'(min_dist_r);
      a_e_r      <= a_e_nxt;
      a_r_r      <= rt_root;
      a_s_r      <= rt_sum;

      b_short_r  <= a_short_r;
      b_k_r      <= b_nrm[29 -: L];
      b_t_r      <= b_nrm[T_W-1:0];
      b_whole_r  <= b_whole_nxt;
      b_s_r      <= a_s_r;

      c_short_r  <= b_short_r;
      c_t0_r     <= rom[c_i0];
      c_diff_r   <= rom[c_i1] - rom[c_i0];
      c_t_r      <= b_t_r;
      c_whole_r  <= b_whole_r;
      c_s_r      <= b_s_r;

      dd_short_r <= c_short_r;
      dd_t0_r    <= c_t0_r;
      dd_prod_r  <= DP_W'(c_diff_r) * DP_W'(c_t_r);
      dd_whole_r <= c_whole_r;
      dd_s_r     <= c_s_r;

      e_short_r  <= dd_short_r;
      e_l2m_r    <= dd_t0_r + tpsk_pkg::LOG_W'(dd_prod_r >> T_W);
      e_whole_r  <= dd_whole_r;
      e_s_r      <= dd_s_r;

      f_short_r  <= e_short_r;
      f_lp_r     <= LP_W'(e_l2m_r) * LP_W'(tpsk_pkg::LN2_Q30);
      f_whole_r  <= e_whole_r;
      f_s_r      <= e_s_r;

      g_short_r  <= f_short_r;
      g_neg_r    <= g_ln[tpsk_pkg::LN_W-1];
      g_mag_r    <= g_ln[tpsk_pkg::LN_W-1] ? tpsk_pkg::LNMAG_W'(-g_ln)
                                           : tpsk_pkg::LNMAG_W'(g_ln);
      g_s_r      <= f_s_r;

      h_short_r  <= g_short_r;
      h_neg_r    <= g_neg_r;
      h_lo_r     <= tpsk_pkg::PART_W'(g_s_r[tpsk_pkg::HALF_W-1:0])
                  * tpsk_pkg::PART_W'(g_mag_r);
      h_hi_r     <= tpsk_pkg::PART_W'(g_s_r[tpsk_pkg::SUM_W-1:tpsk_pkg::HALF_W])
                  * tpsk_pkg::PART_W'(g_mag_r);

      i_short_r  <= h_short_r;
      i_neg_r    <= h_neg_r;
      i_full_r   <= (tpsk_pkg::PROD_W'(h_hi_r) << tpsk_pkg::HALF_W)
                  + tpsk_pkg::PROD_W'(h_lo_r);

      j_short_r  <= i_short_r;
      j_neg_r    <= i_neg_r;
      j_sat_r    <= j_sat_nxt;
      j_mag_r    <= j_mag_nxt;

      o_sat_r    <= !j_short_r && j_sat_r;
      o_val_r    <= j_short_r ? '0 : (j_neg_r ? -j_mag_r : j_mag_r);
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_val_r;
  assign out_tuser  = o_sat_r;
endmodule
`default_nettype wire

FILE: hdl/tpsk_checker.sv
// Port-level checks for the thin-plate spline kernel, bound to the top level.
`default_nettype none
module tpsk_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic         out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata == 64'h7fff_ffff_ffff_ffff || out_tdata == 64'h8000_0000_0000_0000))
    else $error("saturated result not at a limit");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result present after reset");
endmodule

bind thin_plate_spline_kernel tpsk_checker u_tpsk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
